/* rtl/lbcc_pkg.sv */
`default_nettype none

package lbcc_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned SlotsDef      = 16;
  localparam int unsigned StampWidthDef = 32;

  // Fixed sizes
  localparam int unsigned MaxBuckets = 1024;
  localparam int unsigned MaxInitRun = 64;
  localparam int unsigned BktW       = 10;
  localparam int unsigned CntW       = 11;
  localparam int unsigned SlotOutW   = 4;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_READ     = 3'd1,
    ST_INIT     = 3'd2,
    ST_ADDED    = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_DIRTIED  = 3'd5,
    ST_RANGE    = 3'd6,
    ST_NOWRITE  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    MODE_ACCESS = 2'd0,
    MODE_DIRTY  = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_ADD    = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLOTS     = 3'd0,
    CFG_TOTAL     = 3'd1,
    CFG_PRESENT   = 3'd2,
    CFG_FREE_HEAD = 3'd3,
    CFG_FREE_CNT  = 3'd4,
    CFG_WRITABLE  = 3'd5
  } cfg_idx_e;

  // Per-cell update command
  typedef struct packed {
    logic load;        // take tag_i / dirty_i, become held
    logic mark;        // set dirty
    logic drop;        // release slot, clear dirty and stamp
    logic zero_stamp;  // stamp counter wrapped
    logic touch;       // take stamp_i
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/lbcc_cell.sv */
`default_nettype none

module lbcc_cell
  import lbcc_pkg::*;
#(
  parameter int unsigned SLOTS       = SlotsDef,
  parameter int unsigned STAMP_WIDTH = StampWidthDef,
  parameter int unsigned IDX         = 0
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire cell_cmd_t                            cmd_i,
  input  wire logic [BktW-1:0]                      tag_i,
  input  wire logic                                 dirty_i,
  input  wire logic [STAMP_WIDTH-1:0]               stamp_i,
  input  wire logic [BktW-1:0]                      probe_i,
  input  wire logic                                 active_i,
  input  wire logic                                 scan_vld_i,
  input  wire logic [STAMP_WIDTH-1:0]               scan_stamp_i,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] scan_idx_i,
  output logic                                      scan_vld_o,
  output logic [STAMP_WIDTH-1:0]                    scan_stamp_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] scan_idx_o,
  output logic                                      match_o,
  output logic                                      held_o,
  output logic [BktW-1:0]                           tag_o,
  output logic                                      dirty_o
);

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic                   held_q, dirty_q;
  logic [BktW-1:0]        tag_q;
  logic [STAMP_WIDTH-1:0] stamp_q;
  logic                   sv_q;
  logic [STAMP_WIDTH-1:0] ss_q;
  logic [SlotW-1:0]       si_q;
  logic                   take;

  // Slot contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      dirty_q <= 1'b0;
      stamp_q <= '0;
    end else begin
      if (cmd_i.drop) begin
        held_q  <= 1'b0;
        dirty_q <= 1'b0;
      end else if (cmd_i.load) begin
        held_q  <= 1'b1;
        dirty_q <= dirty_i;
      end else if (cmd_i.mark) begin
        dirty_q <= 1'b1;
      end
      if (cmd_i.touch) begin
        stamp_q <= stamp_i;
      end else if (cmd_i.drop || cmd_i.zero_stamp) begin
        stamp_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tag_q <= tag_i;
    end
  end

  // LRU scan stage: keep the older candidate, lower index wins ties
  assign take = active_i && ((IDX == 0) || (stamp_q < scan_stamp_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= scan_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ss_q <= stamp_q;
      si_q <= SlotW'(IDX);
    end else begin
      ss_q <= scan_stamp_i;
      si_q <= scan_idx_i;
    end
  end

  assign scan_vld_o   = sv_q;
  assign scan_stamp_o = ss_q;
  assign scan_idx_o   = si_q;
  assign match_o      = held_q && (tag_q == probe_i);
  assign held_o       = held_q;
  assign tag_o        = tag_q;
  assign dirty_o      = dirty_q;

endmodule

`default_nettype wire

/* rtl/lru_bucket_cache_controller_core.sv */
`default_nettype none

// Slot manager of a fully associative write-back bucket cache with LRU
// replacement. Each slot is a cell holding tag, dirty, held and stamp;
// lookups compare all cells at once. An item is decoded in S_DECIDE,
// then each bucket it places passes S_LOOK and S_FINISH; a placement that
// must evict also passes S_SCAN while the LRU token walks the chain of cells
// (one cell a cycle). One item is handled at a time; results go through an
// output register and a stalled output holds the sequencer. Config writes
// are always accepted.
module lru_bucket_cache_controller_core
  import lbcc_pkg::*;
#(
  parameter int unsigned SLOTS       = SlotsDef,
  parameter int unsigned STAMP_WIDTH = StampWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [BktW-1:0]      bucket_number_i,
  input  wire logic signed [10:0]   next_free_link_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic [SlotOutW-1:0]       slot_o,
  output logic [BktW-1:0]           bucket_o,
  output logic                      evict_valid_o,
  output logic [BktW-1:0]           evict_bucket_o,
  output logic                      write_back_o,
  output logic signed [10:0]        free_link_out_o,
  output logic                      last_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CntW-1:0]      cfg_data_i
);

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FillW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_LOOK, S_SCAN, S_FINISH} state_e;

  state_e                  state_q;
  mode_e                   mode_q;
  status_e                 kind_q;
  logic [BktW-1:0]         tgt_q, addb_q;
  logic signed [10:0]      link_q;
  logic [CntW-1:0]         upto_q;
  logic                    last_final_q, add_after_q;
  logic [SlotW-1:0]        cur_q, fin_slot_q;
  logic                    fin_hit_q, fin_ev_q, fin_wb_q;
  logic [BktW-1:0]         fin_evb_q;
  logic [FillW-1:0]        filled_q;
  logic [STAMP_WIDTH-1:0]  ctr_q;
  logic [CntW-1:0]         present_q, total_q, fcount_q;
  logic signed [10:0]      fhead_q;
  logic [4:0]              slots_cfg_q;
  logic                    writable_q;

  logic                    out_valid_q, out_last_q, out_ev_q, out_wb_q;
  status_e                 out_status_q;
  logic [SlotOutW-1:0]     out_slot_q;
  logic [BktW-1:0]         out_bucket_q, out_evb_q;
  logic signed [10:0]      out_link_q;

  // Cell array wiring
  cell_cmd_t               cmd [SLOTS];
  logic [SLOTS-1:0]        match, held, dirty;
  logic [BktW-1:0]         tag [SLOTS];
  logic                    sc_vld [SLOTS+1];
  logic [STAMP_WIDTH-1:0]  sc_stamp [SLOTS+1];
  logic [SlotW-1:0]        sc_idx [SLOTS+1];

  logic                    out_free, emit, scan_start;
  logic                    any_match;
  logic [SlotW-1:0]        match_idx;
  logic [FillW-1:0]        lim;
  logic                    wrap;
  logic [STAMP_WIDTH-1:0]  ctr_next;
  logic                    new_dirty;
  logic [CntW-1:0]         present_inc, run_acc, run_add;
  logic                    cont;

  // Emission staging
  status_e                 e_status;
  logic [SlotOutW-1:0]     e_slot;
  logic [BktW-1:0]         e_bucket, e_evb;
  logic                    e_ev, e_wb, e_last;
  logic signed [10:0]      e_link;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Effective slot limit
  always_comb begin
    if (slots_cfg_q == '0) begin
      lim = FillW'(1);
    end else if (32'(slots_cfg_q) > 32'(SLOTS)) begin
      lim = FillW'(SLOTS);
    end else begin
      lim = FillW'(slots_cfg_q);
    end
  end

  // Hit detection across cells
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match[i]) begin
        match_idx = match_idx | SlotW'(i);
      end
    end
  end
  assign any_match = |match;

  // Stamp refresh
  assign wrap     = (ctr_q == '1);
  assign ctr_next = wrap ? STAMP_WIDTH'(1) : ctr_q + STAMP_WIDTH'(1);

  assign new_dirty   = ((kind_q != ST_READ) && (kind_q != ST_HIT)) ||
                       (fin_hit_q && dirty[fin_slot_q]);
  assign present_inc = present_q + CntW'(1);
  assign cont        = (present_inc <= upto_q) && (present_inc < CntW'(MaxBuckets));
  assign run_acc     = {1'b0, tgt_q} - present_q + CntW'(1);
  assign run_add     = (present_q < total_q) ? (total_q - present_q) : '0;
  assign scan_start  = (state_q == S_LOOK) && !any_match && !(filled_q < lim);

  // Per-cell commands
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cmd[i] = '0;
      if (state_q == S_FINISH && out_free) begin
        cmd[i].zero_stamp = wrap && (FillW'(i) < filled_q);
        cmd[i].touch      = (fin_slot_q == SlotW'(i));
        cmd[i].load       = (fin_slot_q == SlotW'(i));
      end
      if (state_q == S_DECIDE && out_free && held[cur_q] && cur_q == SlotW'(i)) begin
        cmd[i].mark = (mode_q == MODE_DIRTY);
        cmd[i].drop = (mode_q == MODE_REMOVE);
      end
    end
  end

  assign sc_vld[0]   = scan_start;
  assign sc_stamp[0] = '0;
  assign sc_idx[0]   = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lbcc_cell #(
      .SLOTS       (SLOTS),
      .STAMP_WIDTH (STAMP_WIDTH),
      .IDX         (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd[g]),
      .tag_i        (tgt_q),
      .dirty_i      (new_dirty),
      .stamp_i      (ctr_next),
      .probe_i      (tgt_q),
      .active_i     (FillW'(g) < filled_q),
      .scan_vld_i   (sc_vld[g]),
      .scan_stamp_i (sc_stamp[g]),
      .scan_idx_i   (sc_idx[g]),
      .scan_vld_o   (sc_vld[g+1]),
      .scan_stamp_o (sc_stamp[g+1]),
      .scan_idx_o   (sc_idx[g+1]),
      .match_o      (match[g]),
      .held_o       (held[g]),
      .tag_o        (tag[g]),
      .dirty_o      (dirty[g])
    );
  end

  // Result assembled for this cycle
  always_comb begin
    emit     = 1'b0;
    e_status = ST_RANGE;
    e_slot   = '0;
    e_bucket = '0;
    e_ev     = 1'b0;
    e_evb    = '0;
    e_wb     = 1'b0;
    e_link   = '0;
    e_last   = 1'b1;
    if (state_q == S_DECIDE && out_free) begin
      unique case (mode_q)
        MODE_ACCESS: begin
          if ({1'b0, tgt_q} >= total_q) begin
            emit = 1'b1;
          end else if (!any_match && {1'b0, tgt_q} >= present_q) begin
            if (!writable_q) begin
              emit     = 1'b1;
              e_status = ST_NOWRITE;
            end else if (run_acc > CntW'(MaxInitRun)) begin
              emit = 1'b1;
            end
          end
        end
        MODE_DIRTY, MODE_REMOVE: begin
          emit = 1'b1;
          if (held[cur_q]) begin
            e_status = (mode_q == MODE_DIRTY) ? ST_DIRTIED : ST_REMOVED;
            e_slot   = SlotOutW'(cur_q);
            e_bucket = tag[cur_q];
            e_link   = (mode_q == MODE_REMOVE) ? fhead_q : 11'sd0;
          end
        end
        MODE_ADD: begin
          if (!fhead_q[10]) begin
            emit = ({1'b0, fhead_q[9:0]} >= CntW'(MaxBuckets));
          end else begin
            emit = (total_q >= CntW'(MaxBuckets)) ||
                   (run_add + CntW'(1) > CntW'(MaxInitRun));
          end
        end
        default: emit = 1'b0;
      endcase
    end else if (state_q == S_FINISH && out_free) begin
      emit     = 1'b1;
      e_status = kind_q;
      e_slot   = SlotOutW'(fin_slot_q);
      e_bucket = tgt_q;
      e_ev     = fin_ev_q;
      e_evb    = fin_evb_q;
      e_wb     = fin_wb_q;
      e_last   = (kind_q == ST_INIT) ? (last_final_q && !cont) : 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= e_status;
      out_slot_q   <= e_slot;
      out_bucket_q <= e_bucket;
      out_ev_q     <= e_ev;
      out_evb_q    <= e_evb;
      out_wb_q     <= e_wb;
      out_link_q   <= e_link;
      out_last_q   <= e_last;
    end
  end

  // Sequencer and bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_ACCESS;
      kind_q       <= ST_HIT;
      tgt_q        <= '0;
      link_q       <= '0;
      upto_q       <= '0;
      addb_q       <= '0;
      last_final_q <= 1'b0;
      add_after_q  <= 1'b0;
      cur_q        <= '0;
      filled_q     <= '0;
      ctr_q        <= '0;
      present_q    <= '0;
      total_q      <= '0;
      fhead_q      <= '1;
      fcount_q     <= '0;
      slots_cfg_q  <= 5'd16;
      writable_q   <= 1'b1;
      fin_slot_q   <= '0;
      fin_hit_q    <= 1'b0;
      fin_ev_q     <= 1'b0;
      fin_wb_q     <= 1'b0;
      fin_evb_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_e'(mode_i);
            tgt_q   <= bucket_number_i;
            link_q  <= next_free_link_i;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            if (emit) begin
              state_q <= S_IDLE;
              if (mode_q == MODE_REMOVE && held[cur_q]) begin
                fhead_q  <= {1'b0, tag[cur_q]};
                fcount_q <= (fcount_q == '1) ? fcount_q : fcount_q + CntW'(1);
                cur_q    <= '0;
              end
            end else begin
              state_q      <= S_LOOK;
              last_final_q <= 1'b1;
              add_after_q  <= 1'b0;
              if (mode_q == MODE_ACCESS) begin
                if (any_match) begin
                  kind_q <= ST_HIT;
                end else if ({1'b0, tgt_q} < present_q) begin
                  kind_q <= ST_READ;
                end else begin
                  kind_q <= ST_INIT;
                  upto_q <= {1'b0, tgt_q};
                  tgt_q  <= present_q[BktW-1:0];
                end
              end else if (!fhead_q[10]) begin
                kind_q   <= ST_ADDED;
                tgt_q    <= fhead_q[BktW-1:0];
                fhead_q  <= link_q;
                fcount_q <= (fcount_q == '0) ? fcount_q : fcount_q - CntW'(1);
              end else begin
                addb_q  <= total_q[BktW-1:0];
                total_q <= total_q + CntW'(1);
                if (run_add != '0) begin
                  kind_q       <= ST_INIT;
                  upto_q       <= total_q - CntW'(1);
                  last_final_q <= 1'b0;
                  add_after_q  <= 1'b1;
                  tgt_q        <= present_q[BktW-1:0];
                end else begin
                  kind_q    <= ST_ADDED;
                  tgt_q     <= total_q[BktW-1:0];
                  present_q <= (present_q >= CntW'(MaxBuckets)) ? present_q : present_inc;
                end
              end
            end
          end
        end
        S_LOOK: begin
          fin_ev_q  <= 1'b0;
          fin_wb_q  <= 1'b0;
          fin_evb_q <= '0;
          if (any_match) begin
            fin_slot_q <= match_idx;
            fin_hit_q  <= 1'b1;
            state_q    <= S_FINISH;
          end else if (filled_q < lim) begin
            fin_slot_q <= SlotW'(filled_q);
            fin_hit_q  <= 1'b0;
            filled_q   <= filled_q + FillW'(1);
            state_q    <= S_FINISH;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sc_vld[SLOTS]) begin
            fin_slot_q <= sc_idx[SLOTS];
            fin_hit_q  <= 1'b0;
            fin_ev_q   <= held[sc_idx[SLOTS]];
            fin_wb_q   <= held[sc_idx[SLOTS]] && dirty[sc_idx[SLOTS]];
            fin_evb_q  <= held[sc_idx[SLOTS]] ? tag[sc_idx[SLOTS]] : '0;
            state_q    <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            ctr_q   <= ctr_next;
            cur_q   <= fin_slot_q;
            state_q <= S_IDLE;
            if (kind_q == ST_INIT) begin
              present_q <= present_inc;
              if (cont) begin
                tgt_q   <= present_inc[BktW-1:0];
                state_q <= S_LOOK;
              end else if (add_after_q) begin
                present_q   <= (present_inc >= CntW'(MaxBuckets)) ? present_inc
                                                                  : present_inc + CntW'(1);
                kind_q      <= ST_ADDED;
                tgt_q       <= addb_q;
                add_after_q <= 1'b0;
                state_q     <= S_LOOK;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Config writes load state directly
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SLOTS:     slots_cfg_q <= cfg_data_i[4:0];
          CFG_TOTAL:     total_q <= (cfg_data_i > CntW'(MaxBuckets)) ? CntW'(MaxBuckets)
                                                                     : cfg_data_i;
          CFG_PRESENT:   present_q <= (cfg_data_i > CntW'(MaxBuckets)) ? CntW'(MaxBuckets)
                                                                       : cfg_data_i;
          CFG_FREE_HEAD: fhead_q <= cfg_data_i;
          CFG_FREE_CNT:  fcount_q <= cfg_data_i;
          CFG_WRITABLE:  writable_q <= cfg_data_i[0];
          default:       ;
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign bucket_o        = out_bucket_q;
  assign evict_valid_o   = out_ev_q;
  assign evict_bucket_o  = out_evb_q;
  assign write_back_o    = out_wb_q;
  assign free_link_out_o = out_link_q;
  assign last_o          = out_last_q;

  // A bucket sits in at most one slot
  a_single_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match)) else $error("bucket held by several slots");

  // Fill count never passes the slot count
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(filled_q) <= 32'(SLOTS)) else $error("fill count overflow");

  // An evicted slot is always one that has been filled
  a_victim_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !fin_hit_q) |-> (FillW'(fin_slot_q) < filled_q))
    else $error("victim outside filled slots");

  // Scan token only arrives while waiting for it
  a_scan_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_vld[SLOTS] |-> (state_q == S_SCAN)) else $error("stray scan result");

endmodule

`default_nettype wire
